// ===== rtl/core/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg - shared types and constants for the indexed list store
// Request and status codes, field widths, default sizes and the control
// struct that the top level broadcasts along the row of entry cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

    // Field widths of one request item and one result item
    localparam int REQ_W   = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_BITS   = REQ_W + POS_W + VALUE_W;
    localparam int OUT_BITS  = VALUE_W + STAT_W + COUNT_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Default sizes
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_ITEM_WIDTH = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // What every cell does in the current cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SET,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
    } cell_ctl_t;

endpackage

// ===== rtl/core/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// ilir_cell - one entry of the indexed list store
// Holds one element word. On insert it takes the word of its lower
// neighbor if above the index, on remove the word of its upper neighbor
// if at or above it, and on set or insert at its own index the new word.
// Drives its word onto the read OR-bus when the request addresses it.
// ----------------------------------------------------------------------------
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ITEM_WIDTH = DEF_ITEM_WIDTH,
    parameter int IDX        = 0
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic [ITEM_WIDTH-1:0] below,
    input  logic [ITEM_WIDTH-1:0] above,
    output logic [ITEM_WIDTH-1:0] value,
    output logic [ITEM_WIDTH-1:0] rd_part
);

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW    = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [CW-1:0]         pos_x;
    logic                  at_pos;
    logic                  past_pos;
    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [ITEM_WIDTH-1:0] entry_next;

    assign pos_x    = CW'(ctl.pos);
    assign at_pos   = (MY_IDX == pos_x);
    assign past_pos = (MY_IDX > pos_x);

    // Pick the word this entry holds after the request
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_SET:
            begin
                if (at_pos)
                begin
                    entry_next = wr_data;
                end
            end
            OP_INSERT:
            begin
                if (at_pos)
                begin
                    entry_next = wr_data;
                end
                else if (past_pos)
                begin
                    entry_next = below;
                end
            end
            OP_REMOVE:
            begin
                if (at_pos || past_pos)
                begin
                    entry_next = above;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the entry word
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value   = entry_reg;
    assign rd_part = at_pos ? entry_reg : '0;

endmodule

// ===== rtl/core/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove - ordered list store with insert and remove
// Keeps an ordered list of element words in a row of entry cells with a
// live count, and serves get, set, insert-at-index and remove-at-index.
// ----------------------------------------------------------------------------
// The block takes one request item per clock cycle unless stalled, and
// returns its result item in the next cycle. Every entry sits in its own
// cell and all cells shift together, so an insert or remove moves the whole
// list tail in the accept cycle; the result is held in an output register,
// and a new request is taken whenever that register is empty or is being
// taken in the same cycle. Get and set need an index below the count,
// insert an index up to the count; a bad index gives status 1 (and a get
// reads 0), an insert into a full store gives status 2, and in both cases
// the list is left unchanged. Each result carries the count after the
// request. Entries above the count hold no defined value after reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] req_type, [7:2] position, [39:8] item_value
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [REQ_W-1:0]      req_type;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    item_value;
    logic                  in_fire;

    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    logic                  in_range;
    logic                  ins_range;
    logic                  is_full;

    cell_ctl_t             ctl;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic [ITEM_WIDTH-1:0] cell_val [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_rd  [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_bus;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    rd_val_reg;
    logic [VALUE_W-1:0]    rd_val_next;
    logic [STAT_W-1:0]     status_reg;
    logic [STAT_W-1:0]     status_next;
    logic [COUNT_W-1:0]    res_cnt_reg;

    // Unpack the request item
    assign req_type   = s_axis_tdata[REQ_W-1:0];
    assign position   = s_axis_tdata[REQ_W +: POS_W];
    assign item_value = s_axis_tdata[REQ_W+POS_W +: VALUE_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Range and capacity checks
    assign pos_x     = CMP_W'(position);
    assign cnt_x     = CMP_W'(count_reg);
    assign in_range  = (pos_x < cnt_x);
    assign ins_range = (pos_x <= cnt_x);
    assign is_full   = (count_reg == FULL_CNT);
    assign wr_data   = ITEM_WIDTH'(item_value);

    // Decode the request into a cell command, status and new count
    always_comb
    begin
        ctl.op      = OP_HOLD;
        ctl.pos     = position;
        count_next  = count_reg;
        status_next = ST_OK;
        rd_val_next = '0;
        case (req_type)
            REQ_GET:
            begin
                if (in_range)
                begin
                    rd_val_next = VALUE_W'(rd_bus);
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            REQ_SET:
            begin
                if (in_range)
                begin
                    ctl.op = in_fire ? OP_SET : OP_HOLD;
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            REQ_INSERT:
            begin
                if (!ins_range)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.op     = in_fire ? OP_INSERT : OP_HOLD;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (in_range)
                begin
                    ctl.op     = in_fire ? OP_REMOVE : OP_HOLD;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default:
            begin
                ctl.op = OP_HOLD;
            end
        endcase
    end

    // Row of entry cells, each linked to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] nb_below;
        logic [ITEM_WIDTH-1:0] nb_above;

        if (i == 0)
        begin : g_first
            assign nb_below = cell_val[i];
        end
        else
        begin : g_mid_lo
            assign nb_below = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign nb_above = cell_val[i];
        end
        else
        begin : g_mid_hi
            assign nb_above = cell_val[i+1];
        end

        ilir_cell #(
            .CAPACITY   (CAPACITY),
            .ITEM_WIDTH (ITEM_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .wr_data (wr_data),
            .below   (nb_below),
            .above   (nb_above),
            .value   (cell_val[i]),
            .rd_part (cell_rd[i])
        );
    end

    // Collect the addressed entry from the read OR-bus
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Result register valid: load on accept, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_val_reg  <= rd_val_next;
            status_reg  <= status_next;
            res_cnt_reg <= COUNT_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({res_cnt_reg, status_reg, rd_val_reg});

endmodule
